@@ design/zlfc_pkg.sv @@
// Shared types, codes and field widths of the long FIR convolver.
`default_nettype none

package zlfc_pkg;

  localparam int unsigned ACTION_W   = 2;
  localparam int unsigned TAP_IDX_W  = 12;
  localparam int unsigned GAIN_W     = 16;
  localparam int unsigned GAIN_FRAC  = 12;
  localparam int unsigned KLEN_W     = 13;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned DATA_MAX_W = 32;
  localparam int unsigned Q_DEPTH    = 4;

  // input action codes
  localparam logic [ACTION_W-1:0] ACT_SAMPLE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TAP    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_CLEAR  = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KLEN = 2'd1;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_TAP,
    OP_CLEAR
  } zlfc_op_e;

  // data holds the sample or tap value, sign extended
  typedef struct packed {
    zlfc_op_e               op;
    logic [TAP_IDX_W-1:0]   idx;
    logic [DATA_MAX_W-1:0]  data;
  } zlfc_cmd_t;

  typedef struct packed {
    logic      valid;
    zlfc_cmd_t cmd;
  } zlfc_beat_t;

  typedef struct packed {
    logic init_busy;
    logic busy;
  } zlfc_bstat_t;

endpackage

`default_nettype wire

@@ design/zlfc_front.sv @@
// Front end: accepts input beats, decodes the action and drops no-op beats.
`default_nettype none

module zlfc_front #(
  parameter int MAX_TAPS    = 4096,
  parameter int SAMPLE_BITS = 24
) (
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic        [zlfc_pkg::ACTION_W-1:0]  action_i,
  input  logic signed [SAMPLE_BITS-1:0]         sample_i,
  input  logic        [zlfc_pkg::TAP_IDX_W-1:0] tap_index_i,
  input  logic signed [SAMPLE_BITS-1:0]         tap_value_i,
  input  logic                                  q_full_i,
  input  zlfc_pkg::zlfc_bstat_t                 bstat_i,
  output zlfc_pkg::zlfc_beat_t                  push_o
);

  logic take;
  logic idx_ok;

  assign in_stall_o = q_full_i | bstat_i.init_busy;
  assign take       = in_valid_i & ~in_stall_o;
  assign idx_ok     = int'(tap_index_i) < MAX_TAPS;

  always_comb begin
    push_o          = '0;
    push_o.cmd.idx  = tap_index_i;
    push_o.cmd.op   = zlfc_pkg::OP_SAMPLE;
    push_o.cmd.data = zlfc_pkg::DATA_MAX_W'(sample_i);
    case (action_i)
      zlfc_pkg::ACT_SAMPLE: begin
        push_o.valid = take;
      end
      zlfc_pkg::ACT_TAP: begin
        push_o.cmd.op   = zlfc_pkg::OP_TAP;
        push_o.cmd.data = zlfc_pkg::DATA_MAX_W'(tap_value_i);
        push_o.valid    = take & idx_ok;   // out-of-range tap writes vanish
      end
      zlfc_pkg::ACT_CLEAR: begin
        push_o.cmd.op = zlfc_pkg::OP_CLEAR;
        push_o.valid  = take;
      end
      default: begin
        push_o.valid = 1'b0;               // unknown action: beat consumed, nothing queued
      end
    endcase
  end

endmodule

`default_nettype wire

@@ design/zlfc_cmd_queue.sv @@
// Short command queue between the front and the back end.
`default_nettype none

module zlfc_cmd_queue (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  zlfc_pkg::zlfc_beat_t push_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output zlfc_pkg::zlfc_beat_t head_o
);

  localparam int unsigned PTR_W = $clog2(zlfc_pkg::Q_DEPTH);
  localparam int unsigned CNT_W = $clog2(zlfc_pkg::Q_DEPTH + 1);

  zlfc_pkg::zlfc_cmd_t mem_q [zlfc_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             do_push;
  logic             do_pop;

  assign full_o       = cnt_q == CNT_W'(zlfc_pkg::Q_DEPTH);
  assign head_o.valid = cnt_q != '0;
  assign head_o.cmd   = mem_q[rd_ptr_q];
  assign do_push      = push_i.valid & ~full_o;
  assign do_pop       = pop_i & head_o.valid;

  always_comb begin
    wr_ptr_d = do_push ? PTR_W'(wr_ptr_q + 1'b1) : wr_ptr_q;
    rd_ptr_d = do_pop  ? PTR_W'(rd_ptr_q + 1'b1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push && !do_pop) begin
      cnt_d = CNT_W'(cnt_q + 1'b1);
    end else if (do_pop && !do_push) begin
      cnt_d = CNT_W'(cnt_q - 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_i.cmd;
    end
  end

endmodule

`default_nettype wire

@@ design/zlfc_back.sv @@
// Back end: tap and history memories, MAC sequencer, gain, rounding, output register.
`default_nettype none

module zlfc_back #(
  parameter int MAX_TAPS    = 4096,
  parameter int SAMPLE_BITS = 24,
  parameter int ACC_BITS    = 64
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  zlfc_pkg::zlfc_beat_t                head_i,
  output logic                                pop_o,
  input  logic signed [zlfc_pkg::GAIN_W-1:0]  gain_i,
  input  logic        [zlfc_pkg::KLEN_W-1:0]  klen_i,
  output zlfc_pkg::zlfc_bstat_t               bstat_o,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]       filtered_o,
  output logic                                clipped_o
);

  localparam int unsigned AW        = $clog2(MAX_TAPS);
  localparam int unsigned LEN_W     = $clog2(MAX_TAPS + 1);
  localparam int unsigned PW        = 2 * SAMPLE_BITS;
  localparam int unsigned SUM_W     = ((ACC_BITS > PW) ? ACC_BITS : PW) + 1;
  localparam int unsigned GW        = zlfc_pkg::GAIN_W;
  localparam int unsigned LO_W      = 32;
  localparam int unsigned HI_W      = ACC_BITS - LO_W;
  localparam int unsigned MUL_W     = ACC_BITS + GW;
  localparam int unsigned OUT_SHIFT = SAMPLE_BITS - 1 + zlfc_pkg::GAIN_FRAC;
  localparam int unsigned Q_W       = MUL_W - OUT_SHIFT;
  localparam int unsigned CMP_W     = ((Q_W > SAMPLE_BITS) ? Q_W : SAMPLE_BITS) + 1;

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    $signed(SUM_W'({1'b0, {(ACC_BITS-1){1'b1}}}));
  localparam logic signed [SUM_W-1:0] ACC_MIN = ~ACC_MAX;
  localparam logic [MUL_W-1:0] ROUND_HALF = MUL_W'(1) << (OUT_SHIFT - 1);
  localparam logic [CMP_W-1:0] LIM_NEG    = CMP_W'(1) << (SAMPLE_BITS - 1);
  localparam logic [CMP_W-1:0] LIM_POS    = CMP_W'(LIM_NEG - 1'b1);
  localparam logic [AW-1:0]    LAST_ADDR  = AW'(MAX_TAPS - 1);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_MAG,
    ST_PP_LO,
    ST_PP_HI,
    ST_SUM,
    ST_EMIT
  } state_e;

  // memories
  logic [SAMPLE_BITS-1:0] hist_mem [MAX_TAPS];
  logic [SAMPLE_BITS-1:0] tap_mem  [MAX_TAPS];

  logic                   hist_we, tap_we;
  logic [AW-1:0]          hist_wa, tap_wa;
  logic [SAMPLE_BITS-1:0] hist_wd, tap_wd;

  // control
  state_e                 state_q, state_d;
  logic [LEN_W-1:0]       k_q, k_d;
  logic [AW-1:0]          rd_idx_q, rd_idx_d;
  logic [AW-1:0]          wp_q, wp_d;
  logic [AW-1:0]          wp_next;
  logic [AW-1:0]          clr_addr_q, clr_addr_d;
  logic                   clr_taps_q, clr_taps_d;
  logic                   v1_q, v1_d;
  logic                   v2_q, v2_d;
  logic                   out_valid_q, out_valid_d;
  logic signed [SAMPLE_BITS-1:0] filtered_q, filtered_d;
  logic                   clipped_q, clipped_d;

  // datapath
  logic signed [SAMPLE_BITS-1:0] tap_rd_q, hist_rd_q;
  logic signed [PW-1:0]          prod_q, prod_d;
  logic signed [ACC_BITS-1:0]    acc_q, acc_d;
  logic signed [SUM_W-1:0]       acc_sum;
  logic                          clip_q, clip_d;
  logic [ACC_BITS-1:0]           mag_q, mag_d;
  logic [GW-1:0]                 gmag_q, gmag_d;
  logic                          neg_q, neg_d;
  logic [LO_W+GW-1:0]            pp_lo_q, pp_lo_d;
  logic [HI_W+GW-1:0]            pp_hi_q, pp_hi_d;
  logic [MUL_W-1:0]              sum_q, sum_d;
  logic signed [SAMPLE_BITS-1:0] x_q, x_d;
  logic                          pass_q, pass_d;

  logic [LEN_W-1:0]       len;
  logic [CMP_W-1:0]       q_ext, lim, q_sat;
  logic                   sat;
  logic [SAMPLE_BITS-1:0] res;
  logic                   out_free;

  assign len = (int'(klen_i) > MAX_TAPS) ? LEN_W'(MAX_TAPS) : LEN_W'(klen_i);
  assign wp_next  = (wp_q == LAST_ADDR) ? '0 : AW'(wp_q + 1'b1);
  assign out_free = ~out_valid_q | ~out_stall_i;

  // output rounding and saturation on the registered sum
  assign q_ext = CMP_W'(sum_q >> OUT_SHIFT);
  assign lim   = neg_q ? LIM_NEG : LIM_POS;
  assign sat   = q_ext > lim;
  assign q_sat = sat ? lim : q_ext;
  assign res   = neg_q ? SAMPLE_BITS'(-q_sat) : SAMPLE_BITS'(q_sat);

  assign acc_sum = SUM_W'(acc_q) + SUM_W'(prod_q);

  assign bstat_o.init_busy = (state_q == ST_CLEAR) & clr_taps_q;
  assign bstat_o.busy      = state_q != ST_IDLE;

  assign out_valid_o = out_valid_q;
  assign filtered_o  = filtered_q;
  assign clipped_o   = clipped_q;

  always_comb begin
    state_d     = state_q;
    k_d         = k_q;
    rd_idx_d    = rd_idx_q;
    wp_d        = wp_q;
    clr_addr_d  = clr_addr_q;
    clr_taps_d  = clr_taps_q;
    v1_d        = 1'b0;
    v2_d        = v1_q;
    out_valid_d = out_valid_q & out_stall_i;
    filtered_d  = filtered_q;
    clipped_d   = clipped_q;
    pop_o       = 1'b0;
    hist_we     = 1'b0;
    hist_wa     = clr_addr_q;
    hist_wd     = '0;
    tap_we      = 1'b0;
    tap_wa      = clr_addr_q;
    tap_wd      = '0;

    prod_d  = tap_rd_q * hist_rd_q;
    acc_d   = acc_q;
    clip_d  = clip_q;
    mag_d   = mag_q;
    gmag_d  = gmag_q;
    neg_d   = neg_q;
    pp_lo_d = pp_lo_q;
    pp_hi_d = pp_hi_q;
    sum_d   = sum_q;
    x_d     = x_q;
    pass_d  = pass_q;

    // saturating accumulate at the end of the MAC pipe
    if (v2_q) begin
      if (acc_sum > ACC_MAX) begin
        acc_d  = ACC_MAX[ACC_BITS-1:0];
        clip_d = 1'b1;
      end else if (acc_sum < ACC_MIN) begin
        acc_d  = ACC_MIN[ACC_BITS-1:0];
        clip_d = 1'b1;
      end else begin
        acc_d = acc_sum[ACC_BITS-1:0];
      end
    end

    case (state_q)
      ST_CLEAR: begin
        hist_we    = 1'b1;
        tap_we     = clr_taps_q;
        clr_addr_d = AW'(clr_addr_q + 1'b1);
        if (clr_addr_q == LAST_ADDR) begin
          clr_addr_d = '0;
          clr_taps_d = 1'b0;
          wp_d       = '0;
          state_d    = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (head_i.valid) begin
          pop_o = 1'b1;
          case (head_i.cmd.op)
            zlfc_pkg::OP_TAP: begin
              tap_we = 1'b1;
              tap_wa = AW'(head_i.cmd.idx);
              tap_wd = head_i.cmd.data[SAMPLE_BITS-1:0];
            end
            zlfc_pkg::OP_CLEAR: begin
              clr_addr_d = '0;
              state_d    = ST_CLEAR;
            end
            zlfc_pkg::OP_SAMPLE: begin
              wp_d     = wp_next;
              hist_we  = 1'b1;
              hist_wa  = wp_next;
              hist_wd  = head_i.cmd.data[SAMPLE_BITS-1:0];
              x_d      = head_i.cmd.data[SAMPLE_BITS-1:0];
              acc_d    = '0;
              clip_d   = 1'b0;
              k_d      = '0;
              rd_idx_d = wp_next;
              pass_d   = len == '0;
              state_d  = (len == '0) ? ST_EMIT : ST_MAC;
            end
            default: begin
            end
          endcase
        end
      end
      ST_MAC: begin
        v1_d     = 1'b1;
        k_d      = LEN_W'(k_q + 1'b1);
        rd_idx_d = (rd_idx_q == '0) ? LAST_ADDR : AW'(rd_idx_q - 1'b1);
        if (LEN_W'(k_q + 1'b1) == len) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!v1_q && !v2_q) begin
          state_d = ST_MAG;
        end
      end
      ST_MAG: begin
        mag_d   = acc_q[ACC_BITS-1] ? ACC_BITS'(-acc_q) : ACC_BITS'(acc_q);
        gmag_d  = gain_i[GW-1] ? GW'(-gain_i) : GW'(gain_i);
        neg_d   = acc_q[ACC_BITS-1] ^ gain_i[GW-1];
        state_d = ST_PP_LO;
      end
      ST_PP_LO: begin
        pp_lo_d = (LO_W+GW)'(mag_q[LO_W-1:0]) * (LO_W+GW)'(gmag_q);
        state_d = ST_PP_HI;
      end
      ST_PP_HI: begin
        pp_hi_d = (HI_W+GW)'(mag_q[ACC_BITS-1:LO_W]) * (HI_W+GW)'(gmag_q);
        state_d = ST_SUM;
      end
      ST_SUM: begin
        sum_d   = (MUL_W'(pp_hi_q) << LO_W) + MUL_W'(pp_lo_q) + ROUND_HALF;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          filtered_d  = pass_q ? x_q : $signed(res);
          clipped_d   = pass_q ? 1'b0 : (clip_q | sat);
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      k_q         <= '0;
      rd_idx_q    <= '0;
      wp_q        <= '0;
      clr_addr_q  <= '0;
      clr_taps_q  <= 1'b1;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
      filtered_q  <= '0;
      clipped_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      k_q         <= k_d;
      rd_idx_q    <= rd_idx_d;
      wp_q        <= wp_d;
      clr_addr_q  <= clr_addr_d;
      clr_taps_q  <= clr_taps_d;
      v1_q        <= v1_d;
      v2_q        <= v2_d;
      out_valid_q <= out_valid_d;
      filtered_q  <= filtered_d;
      clipped_q   <= clipped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    acc_q   <= acc_d;
    clip_q  <= clip_d;
    mag_q   <= mag_d;
    gmag_q  <= gmag_d;
    neg_q   <= neg_d;
    pp_lo_q <= pp_lo_d;
    pp_hi_q <= pp_hi_d;
    sum_q   <= sum_d;
    x_q     <= x_d;
    pass_q  <= pass_d;
  end

  always_ff @(posedge clk_i) begin
    if (hist_we) begin
      hist_mem[hist_wa] <= hist_wd;
    end
    if (tap_we) begin
      tap_mem[tap_wa] <= tap_wd;
    end
    hist_rd_q <= hist_mem[rd_idx_q];
    tap_rd_q  <= tap_mem[k_q[AW-1:0]];
  end

endmodule

`default_nettype wire

@@ design/zero_latency_long_fir_convolver.sv @@
// Top level of the long direct-form FIR convolver: config registers, front, queue, back.
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+-------------------------------------
//  in      | input     | in_valid_i / in_stall_o  | action, sample, tap_index, tap_value
//  out     | output    | out_valid_o / out_stall_i| filtered, clipped
//  cfg     | input     | cfg_we_i                 | cfg_index_i, cfg_data_i
//
// A sample beat in the back end runs len MACs, len = min(kernel_len, MAX_TAPS):
// one MAC per cycle, one tap and one history read per cycle through a three-stage pipe,
// then magnitude, two 32x16 partial products, rounding and the output register.
// A zero kernel length skips the MAC and the gain stages and passes the sample through.
// After reset a clearing pass zeroes both memories; in_stall_o is high throughout, config
// writes are still taken. The four-deep command queue lets the input side keep taking
// beats while the back end works or the output is stalled.
`default_nettype none

module zero_latency_long_fir_convolver #(
  parameter int MAX_TAPS    = 4096,
  parameter int SAMPLE_BITS = 24,
  parameter int ACC_BITS    = 64
) (
  input  logic                                     clk_i,
  input  logic                                     rst_ni,
  // input beats
  input  logic                                     in_valid_i,
  output logic                                     in_stall_o,
  input  logic        [zlfc_pkg::ACTION_W-1:0]     action_i,
  input  logic signed [SAMPLE_BITS-1:0]            sample_i,
  input  logic        [zlfc_pkg::TAP_IDX_W-1:0]    tap_index_i,
  input  logic signed [SAMPLE_BITS-1:0]            tap_value_i,
  // result beats
  output logic                                     out_valid_o,
  input  logic                                     out_stall_i,
  output logic signed [SAMPLE_BITS-1:0]            filtered_o,
  output logic                                     clipped_o,
  // config writes
  input  logic                                     cfg_we_i,
  input  logic        [zlfc_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic        [zlfc_pkg::CFG_DATA_W-1:0]   cfg_data_i
);

  logic signed [zlfc_pkg::GAIN_W-1:0] gain_q, gain_d;
  logic        [zlfc_pkg::KLEN_W-1:0] klen_q, klen_d;

  zlfc_pkg::zlfc_beat_t  push;
  zlfc_pkg::zlfc_beat_t  head;
  zlfc_pkg::zlfc_bstat_t bstat;
  logic                  q_full;
  logic                  pop;

  // config registers; unknown indexes are ignored
  always_comb begin
    gain_d = gain_q;
    klen_d = klen_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        zlfc_pkg::CFG_GAIN: gain_d = $signed(cfg_data_i[zlfc_pkg::GAIN_W-1:0]);
        zlfc_pkg::CFG_KLEN: klen_d = cfg_data_i[zlfc_pkg::KLEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= zlfc_pkg::GAIN_W'(4096);   // 1.0 in Q4.12
      klen_q <= '0;
    end else begin
      gain_q <= gain_d;
      klen_q <= klen_d;
    end
  end

  zlfc_front #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .sample_i    (sample_i),
    .tap_index_i (tap_index_i),
    .tap_value_i (tap_value_i),
    .q_full_i    (q_full),
    .bstat_i     (bstat),
    .push_o      (push)
  );

  zlfc_cmd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .full_o (q_full),
    .pop_i  (pop),
    .head_o (head)
  );

  zlfc_back #(
    .MAX_TAPS    (MAX_TAPS),
    .SAMPLE_BITS (SAMPLE_BITS),
    .ACC_BITS    (ACC_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .pop_o       (pop),
    .gain_i      (gain_q),
    .klen_i      (klen_q),
    .bstat_o     (bstat),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .clipped_o   (clipped_o)
  );

  // no input beat gets in while the reset clearing pass runs
  a_init_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bstat.init_busy |-> in_stall_o)
    else $error("input taken during clearing pass");

  // the queue is never pushed while full
  a_no_push_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push.valid |-> !q_full)
    else $error("push into full command queue");

  // a result only appears after back-end work
  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(bstat.busy))
    else $error("result without back-end work");

  // nothing is popped while the back end is busy
  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> (head.valid && !bstat.busy))
    else $error("pop while back end busy");

endmodule

`default_nettype wire

@@ test/testbench.sv @@
// Self-checking testbench for the long direct-form FIR convolver.
module testbench;
  import zlfc_pkg::*;

  localparam int MAX_TAPS  = 4096;
  localparam int SB        = 24;
  localparam int HALF      = 5;
  localparam int LIMIT     = 3_000_000;
  localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
  localparam longint ACC_MIN = -ACC_MAX - 1;

  // codes the package leaves unnamed: the spare action and the spare register slots
  localparam logic [ACTION_W-1:0]  ACT_IGNORED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED_B = 2'd3;

  localparam logic signed [SB-1:0] Q23_MAX = 24'sh7FFFFF;
  localparam logic signed [SB-1:0] Q23_MIN = 24'sh800000;

  typedef struct {
    logic [ACTION_W-1:0]  action;
    logic signed [SB-1:0] sample;
    logic [TAP_IDX_W-1:0] tap_index;
    logic signed [SB-1:0] tap_value;
  } audio_beat_t;

  typedef struct {
    logic signed [SB-1:0] filtered;
    logic                 clipped;
  } filtered_beat_t;

  // DUT ports, all known from time zero
  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_stall_o;
  logic [ACTION_W-1:0]   action_i    = '0;
  logic signed [SB-1:0]  sample_i    = '0;
  logic [TAP_IDX_W-1:0]  tap_index_i = '0;
  logic signed [SB-1:0]  tap_value_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic signed [SB-1:0]  filtered_o;
  logic                  clipped_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i  = '0;

  zero_latency_long_fir_convolver dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .sample_i    (sample_i),
    .tap_index_i (tap_index_i),
    .tap_value_i (tap_value_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .filtered_o  (filtered_o),
    .clipped_o   (clipped_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #(HALF) clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Filter state mirrored on the bench side
  // ---------------------------------------------------------------------------
  logic signed [SB-1:0]     tap_mem     [MAX_TAPS];
  logic signed [SB-1:0]     sample_hist [MAX_TAPS];
  int unsigned              newest_slot = 0;
  logic signed [GAIN_W-1:0] gain_q412   = 16'sd4096;
  logic [KLEN_W-1:0]        klen        = '0;

  audio_beat_t    beats_to_send [$];
  filtered_beat_t filtered_due  [$];

  // bookkeeping
  int          mismatches    = 0;
  int unsigned cycle_count   = 0;
  int          quiet_tail    = 0;   // cycles the block may still spend on no-result beats
  int          widest_kernel = 0;
  int          n_samples = 0, n_taps = 0, n_clears = 0, n_ignored = 0;
  int          n_checked = 0, n_clipped = 0, n_cfg = 0;

  // handshake and idling state
  logic           in_taken  = 1'b0;
  int             gap_left  = 0;
  int             calm_left = 0;
  int             stall_left = 0;
  int             open_left  = 0;
  int             stall_roll;
  audio_beat_t    next_beat;
  filtered_beat_t due_beat;
  logic signed [SB-1:0] want_filtered;
  logic                 want_clipped;

  initial begin
    for (int i = 0; i < MAX_TAPS; i++) begin
      tap_mem[i]     = '0;
      sample_hist[i] = '0;
    end
  end

  // One sample step: push into the ring, then direct-form MAC, gain, round, saturate.
  function automatic void convolve_sample(input logic signed [SB-1:0] x,
                                          output logic signed [SB-1:0] y,
                                          output logic clip);
    int unsigned len;
    int unsigned slot;
    longint      acc;
    longint      prod;
    logic        neg;
    logic [63:0] mag;
    int          gi;
    logic [79:0] wide;
    logic [79:0] lim;
    newest_slot = (newest_slot == MAX_TAPS - 1) ? 0 : newest_slot + 1;
    sample_hist[newest_slot] = x;
    len  = (klen > MAX_TAPS) ? MAX_TAPS : klen;
    clip = 1'b0;
    if (len == 0) begin
      // pass-through, gain not applied
      y = x;
      return;
    end
    acc = 0;
    for (int unsigned k = 0; k < len; k++) begin
      slot = (newest_slot >= k) ? newest_slot - k : newest_slot + MAX_TAPS - k;
      prod = longint'(tap_mem[k]) * longint'(sample_hist[slot]);
      if (prod > 0 && acc > ACC_MAX - prod) begin
        acc = ACC_MAX; clip = 1'b1;
      end else if (prod < 0 && acc < ACC_MIN - prod) begin
        acc = ACC_MIN; clip = 1'b1;
      end else begin
        acc += prod;
      end
    end
    // sign-magnitude product, round half away from zero, drop 23+12 fraction bits
    gi   = gain_q412;
    neg  = (acc < 0) != (gi < 0);
    mag  = (acc < 0) ? (~acc + 64'd1) : acc;
    wide = 80'(mag) * 80'((gi < 0) ? -gi : gi);
    wide = (wide + (80'd1 << (SB - 1 + GAIN_FRAC - 1))) >> (SB - 1 + GAIN_FRAC);
    lim  = neg ? (80'd1 << (SB - 1)) : ((80'd1 << (SB - 1)) - 80'd1);
    if (wide > lim) begin
      wide = lim; clip = 1'b1;
    end
    y = neg ? -wide[SB-1:0] : wide[SB-1:0];
  endfunction

  // ---------------------------------------------------------------------------
  // Monitor: everything sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    cycle_count++;
    in_taken = rst_ni && in_valid_i && !in_stall_o;

    if (rst_ni && cfg_we_i) begin
      n_cfg++;
      case (cfg_index_i)
        CFG_GAIN: gain_q412 = signed'(cfg_data_i[GAIN_W-1:0]);
        CFG_KLEN: klen      = cfg_data_i[KLEN_W-1:0];
        default: ;  // spare slots have no effect
      endcase
    end

    if (in_taken) begin
      case (action_i)
        ACT_SAMPLE: begin
          n_samples++;
          convolve_sample(sample_i, want_filtered, want_clipped);
          filtered_due.push_back('{filtered: want_filtered, clipped: want_clipped});
        end
        ACT_TAP: begin
          n_taps++;
          tap_mem[tap_index_i] = tap_value_i;
        end
        ACT_CLEAR: begin
          n_clears++;
          for (int i = 0; i < MAX_TAPS; i++) sample_hist[i] = '0;
          newest_slot = 0;
        end
        default: n_ignored++;
      endcase
    end

    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (filtered_due.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result beat, expected none, actual filtered %0d clipped %0b",
                 $time, filtered_o, clipped_o);
      end else begin
        due_beat = filtered_due.pop_front();
        n_checked++;
        if (due_beat.clipped) n_clipped++;
        if (filtered_o !== due_beat.filtered) begin
          mismatches++;
          $display("%0t: filtered expected %0d, actual %0d",
                   $time, due_beat.filtered, filtered_o);
        end
        if (clipped_o !== due_beat.clipped) begin
          mismatches++;
          $display("%0t: clipped expected %0b, actual %0b",
                   $time, due_beat.clipped, clipped_o);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Input driver: falling edge, holds a beat until it is taken
  // ---------------------------------------------------------------------------
  // mostly short gaps, a few long ones, and now and then a stretch with none
  function automatic int next_gap();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4)  calm_left = $urandom_range(10, 40);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 20);
    return $urandom_range(50, 300);
  endfunction

  always @(negedge clk_i) begin
    if (rst_ni && !(in_valid_i && !in_taken)) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid_i <= 1'b0;
      end else if (beats_to_send.size() != 0) begin
        next_beat    = beats_to_send.pop_front();
        action_i    <= next_beat.action;
        sample_i    <= next_beat.sample;
        tap_index_i <= next_beat.tap_index;
        tap_value_i <= next_beat.tap_value;
        in_valid_i  <= 1'b1;
        gap_left     = next_gap();
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall: short bursts, some long holds, open stretches in between
  always @(negedge clk_i) begin
    if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if (open_left > 0) begin
      open_left--;
      out_stall_i <= 1'b0;
    end else begin
      stall_roll = $urandom_range(0, 99);
      if (stall_roll < 60) begin
        open_left   = $urandom_range(0, 6);
        out_stall_i <= 1'b0;
      end else if (stall_roll < 66) begin
        open_left   = $urandom_range(50, 200);
        out_stall_i <= 1'b0;
      end else if (stall_roll < 92) begin
        stall_left  = $urandom_range(0, 3);
        out_stall_i <= 1'b1;
      end else if (stall_roll < 99) begin
        stall_left  = $urandom_range(4, 30);
        out_stall_i <= 1'b1;
      end else begin
        stall_left  = $urandom_range(100, 300);
        out_stall_i <= 1'b1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  function automatic logic [SB-1:0] rand_q23();
    case ($urandom_range(0, 9))
      0:       return Q23_MAX;
      1:       return Q23_MIN;
      2:       return SB'(int'($urandom_range(0, 512)) - 256);
      default: return SB'($urandom);
    endcase
  endfunction

  // no-result beats leave the back end busy after the last result shows up
  task automatic push_beat(input logic [ACTION_W-1:0] act, input logic [SB-1:0] smp,
                           input logic [TAP_IDX_W-1:0] idx, input logic [SB-1:0] tv);
    beats_to_send.push_back('{action: act, sample: smp, tap_index: idx, tap_value: tv});
    if (act == ACT_SAMPLE)     quiet_tail = 0;
    else if (act == ACT_CLEAR) quiet_tail += MAX_TAPS + 16;
    else                       quiet_tail += 4;
  endtask

  task automatic push_sample(input logic [SB-1:0] smp);
    push_beat(ACT_SAMPLE, smp, TAP_IDX_W'($urandom), SB'($urandom));
  endtask

  task automatic push_tap(input logic [TAP_IDX_W-1:0] idx, input logic [SB-1:0] tv);
    push_beat(ACT_TAP, SB'($urandom), idx, tv);
  endtask

  // sender holds off until every result is in and the block has gone quiet
  task automatic drain();
    while (beats_to_send.size() != 0 || in_valid_i || filtered_due.size() != 0)
      @(posedge clk_i);
    repeat (quiet_tail + 16) @(posedge clk_i);
    quiet_tail = 0;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Random phase: new gain and length, then a mix weighted toward samples.
  // Tap writes mostly land inside the active length so they show up in the output.
  task automatic random_phase(input logic [CFG_DATA_W-1:0] gain_word,
                              input logic [CFG_DATA_W-1:0] klen_word, input int n);
    int eff;
    int r;
    logic [TAP_IDX_W-1:0] idx;
    drain();
    write_reg(CFG_GAIN, gain_word);
    write_reg(CFG_KLEN, klen_word);
    eff = (klen_word[KLEN_W-1:0] > MAX_TAPS) ? MAX_TAPS : klen_word[KLEN_W-1:0];
    if (eff > widest_kernel) widest_kernel = eff;
    repeat (n) begin
      r   = $urandom_range(0, 99);
      idx = TAP_IDX_W'($urandom);
      if (eff > 0 && $urandom_range(0, 3) != 0) idx = TAP_IDX_W'($urandom_range(0, eff - 1));
      if (r < 62)      push_beat(ACT_SAMPLE, rand_q23(), idx, rand_q23());
      else if (r < 87) push_beat(ACT_TAP, rand_q23(), idx, rand_q23());
      else if (r < 93) push_beat(ACT_CLEAR, rand_q23(), idx, rand_q23());
      else             push_beat(ACT_IGNORED, rand_q23(), idx, rand_q23());
    end
  endtask

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // reset config: zero length, so samples come straight back; load taps meanwhile
    push_sample(Q23_MAX);
    push_sample(Q23_MIN);
    push_sample('0);
    push_beat(ACT_IGNORED, SB'($urandom), TAP_IDX_W'($urandom), SB'($urandom));
    push_tap(12'd0, Q23_MAX);
    push_tap(12'd1, Q23_MIN);
    push_tap(12'd2, 24'sh400000);
    push_tap(12'd3, -24'sh400000);
    push_tap(12'hFFF, rand_q23());
    push_beat(ACT_CLEAR, SB'($urandom), TAP_IDX_W'($urandom), SB'($urandom));

    // four taps at unity gain; upper data bits must be dropped from the length
    drain();
    write_reg(CFG_KLEN, 16'hE004);
    widest_kernel = 4;
    push_sample(Q23_MAX);
    push_sample(Q23_MIN);
    push_sample(Q23_MAX);
    push_sample(24'sd1);
    push_sample(-24'sd1);

    // largest positive gain drives the output into positive saturation
    drain();
    write_reg(CFG_GAIN, 16'h7FFF);
    push_sample(Q23_MAX);
    push_sample(Q23_MIN);
    push_sample(Q23_MAX);

    // most negative gain; spare register slots must not disturb anything
    drain();
    write_reg(CFG_GAIN, 16'h8000);
    write_reg(CFG_UNUSED_A, CFG_DATA_W'($urandom));
    write_reg(CFG_UNUSED_B, CFG_DATA_W'($urandom));
    push_sample(Q23_MAX);
    push_sample(Q23_MIN);
    push_sample(Q23_MAX);
    push_beat(ACT_CLEAR, SB'($urandom), TAP_IDX_W'($urandom), SB'($urandom));
    push_sample(Q23_MAX);

    // random part: mostly short kernels, a few at or past the tap memory size
    random_phase(CFG_DATA_W'($urandom), 16'd16, 18);
    random_phase(16'h0000, 16'd1, 10);
    random_phase(16'd4096, CFG_DATA_W'($urandom_range(2, 64)), 18);
    random_phase(16'h7FFF, 16'd8, 14);
    random_phase(CFG_DATA_W'($urandom), 16'd4096, 5);
    random_phase(CFG_DATA_W'($urandom_range(32768, 65535)), 16'hFFFF, 4);
    random_phase(CFG_DATA_W'($urandom), 16'd4097, 3);
    random_phase(CFG_DATA_W'($urandom), 16'h0000, 12);
    random_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 200)), 20);
    random_phase(CFG_DATA_W'($urandom), 16'd4095, 4);
    random_phase(CFG_DATA_W'($urandom), CFG_DATA_W'($urandom_range(1, 32)), 10);

    drain();
    repeat (MAX_TAPS + 64) @(posedge clk_i);

    if (filtered_due.size() != 0) begin
      mismatches += filtered_due.size();
      $display("%0t: %0d results expected, actual none", $time, filtered_due.size());
    end

    $display("run: %0d samples, %0d tap writes, %0d history clears, %0d ignored beats, %0d reg writes",
             n_samples, n_taps, n_clears, n_ignored, n_cfg);
    $display("run: %0d results checked (%0d saturated), kernels up to %0d taps",
             n_checked, n_clipped, widest_kernel);
    if (mismatches == 0)
      $display("zero_latency_long_fir_convolver: match");
    else
      $display("zero_latency_long_fir_convolver: mismatch");
    $finish;
  end

  // hang guard
  initial begin
    while (cycle_count < LIMIT) @(posedge clk_i);
    $display("%0t: cycle limit reached", $time);
    $display("zero_latency_long_fir_convolver: mismatch");
    $finish;
  end

endmodule

@@ zero_latency_long_fir_convolver.f @@
design/zlfc_pkg.sv
design/zlfc_front.sv
design/zlfc_cmd_queue.sv
design/zlfc_back.sv
design/zero_latency_long_fir_convolver.sv
test/testbench.sv
